FILE: design/lmm_pkg.sv
// Shared constants and types for the line median block.
package lmm_pkg;

  localparam int MAX_LINE    = 64;
  localparam int SAMPLE_BITS = 32;
  localparam int MEDIAN_W    = 33;
  localparam int CNT_W       = $clog2(MAX_LINE + 1);
  localparam int SHIFT_W     = (CNT_W > 1) ? CNT_W - 1 : 1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_RUN   = 2'b01,
    S_DRAIN = 2'b10
  } state_t;

endpackage

FILE: design/lmm_cell.sv
// One slot of the sorted chain: holds a sample and an occupied flag.
module lmm_cell (
  input  logic               clk,
  input  logic               rst,
  input  lmm_pkg::cell_ctrl_t ctrl,
  input  lmm_pkg::sample_t   din,
  input  lmm_pkg::sample_t   prev_val,
  input  logic               prev_occ,
  input  logic               prev_take,
  input  lmm_pkg::sample_t   next_val,
  input  logic               next_occ,
  output lmm_pkg::sample_t   val,
  output logic               occ,
  output logic               take
);

  // Empty slot, or a stored value strictly above the new one: new value lands here or below.
  assign take = !occ || (val > din);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      occ <= 1'b0;
    end else if (ctrl.shift) begin
      occ <= next_occ;
    end else if (ctrl.insert) begin
      occ <= occ | prev_occ;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      val <= next_val;
    end else if (ctrl.insert) begin
      if (prev_take) begin
        val <= prev_val;
      end else if (take) begin
        val <= din;
      end
    end
  end

endmodule

FILE: design/lmm_chain.sv
// Row of sorting cells: insert moves toward the tail, shift drains toward the head.
module lmm_chain (
  input  logic                clk,
  input  logic                rst,
  input  lmm_pkg::cell_ctrl_t ctrl,
  input  lmm_pkg::sample_t    din,
  output lmm_pkg::sample_t    head0,
  output lmm_pkg::sample_t    head1
);

  lmm_pkg::sample_t vals [lmm_pkg::MAX_LINE];
  logic [lmm_pkg::MAX_LINE-1:0] occs;
  logic [lmm_pkg::MAX_LINE-1:0] takes;

  for (genvar i = 0; i < lmm_pkg::MAX_LINE; i++) begin : g_cell
    lmm_pkg::sample_t pv;
    lmm_pkg::sample_t nv;
    logic             po;
    logic             pt;
    logic             no;

    if (i == 0) begin : g_head
      assign pv = '0;
      assign po = 1'b1;
      assign pt = 1'b0;
    end else begin : g_body
      assign pv = vals[i-1];
      assign po = occs[i-1];
      assign pt = takes[i-1];
    end

    if (i == lmm_pkg::MAX_LINE - 1) begin : g_tail
      assign nv = '0;
      assign no = 1'b0;
    end else begin : g_inner
      assign nv = vals[i+1];
      assign no = occs[i+1];
    end

    lmm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .din       (din),
      .prev_val  (pv),
      .prev_occ  (po),
      .prev_take (pt),
      .next_val  (nv),
      .next_occ  (no),
      .val       (vals[i]),
      .occ       (occs[i]),
      .take      (takes[i])
    );
  end

  assign head0 = vals[0];
  assign head1 = vals[1];

endmodule

FILE: design/line_median_with_missing_core.sv
// Top level of the streaming line median with missing-sample exclusion.
// Samples of a line are taken one per cycle and insertion-sorted in place by a row of 64
// cells; missing samples only skip the row. After the beat that ends a line, the row drains
// toward its head one slot per cycle until the middle pair sits in the first two cells; during
// the drain input is stalled, and the capture that ends it is held further while an earlier
// result still waits in the output register. The result sits in an output register, so
// the next line can start while it waits. Valid samples past 64 in one line are dropped and
// flagged as overflow.
module line_median_with_missing_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [31:0]                  sample,
  input  logic                                is_missing,
  input  logic                                last_in_line,
  input  logic                                in_valid,
  output logic                                in_stall,
  output logic signed [lmm_pkg::MEDIAN_W-1:0] median_half_units,
  output logic                                all_missing,
  output logic                                overflow,
  output logic                                out_valid,
  input  logic                                out_stall
);

  lmm_pkg::state_t             state;
  lmm_pkg::state_t             state_next;
  logic [lmm_pkg::CNT_W-1:0]   count;
  logic [lmm_pkg::CNT_W-1:0]   count_after;
  logic [lmm_pkg::SHIFT_W-1:0] shifts;
  logic                        overflow_seen;
  lmm_pkg::cell_ctrl_t         ctrl;
  lmm_pkg::sample_t            din;
  lmm_pkg::sample_t            head0;
  lmm_pkg::sample_t            head1;
  logic                        accept;
  logic                        full;
  logic                        ins;
  logic                        out_free;
  logic                        capture;
  logic signed [lmm_pkg::MEDIAN_W-1:0] med;

  assign din         = sample[lmm_pkg::SAMPLE_BITS-1:0];
  assign in_stall    = (state != lmm_pkg::S_RUN);
  assign accept      = in_valid && !in_stall;
  assign full        = (count == lmm_pkg::CNT_W'(lmm_pkg::MAX_LINE));
  assign ins         = accept && !is_missing && !full;
  assign count_after = count + lmm_pkg::CNT_W'(ins);
  assign out_free    = !out_valid || !out_stall;
  assign capture     = (state == lmm_pkg::S_DRAIN) && (shifts == '0) && out_free;

  always_comb begin
    ctrl.insert = ins;
    ctrl.shift  = (state == lmm_pkg::S_DRAIN) && (shifts != '0);
    ctrl.clear  = capture;
  end

  lmm_chain u_chain (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .din   (din),
    .head0 (head0),
    .head1 (head1)
  );

  // Odd count: double the middle; even count: add the middle pair.
  always_comb begin
    if (count[0]) begin
      med = lmm_pkg::MEDIAN_W'(head0) + lmm_pkg::MEDIAN_W'(head0);
    end else begin
      med = lmm_pkg::MEDIAN_W'(head0) + lmm_pkg::MEDIAN_W'(head1);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lmm_pkg::S_RUN: begin
        if (accept && last_in_line) begin
          state_next = lmm_pkg::S_DRAIN;
        end
      end
      lmm_pkg::S_DRAIN: begin
        if (capture) begin
          state_next = lmm_pkg::S_RUN;
        end
      end
      default: state_next = lmm_pkg::S_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= lmm_pkg::S_RUN;
      count         <= '0;
      shifts        <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (capture) begin
        count         <= '0;
        overflow_seen <= 1'b0;
      end else begin
        count <= count_after;
        if (accept && !is_missing && full) begin
          overflow_seen <= 1'b1;
        end
      end
      // Drain until the lower middle sample reaches the head.
      if (accept && last_in_line) begin
        if (count_after == '0) begin
          shifts <= '0;
        end else begin
          shifts <= lmm_pkg::SHIFT_W'((count_after - lmm_pkg::CNT_W'(1)) >> 1);
        end
      end else if (ctrl.shift) begin
        shifts <= shifts - lmm_pkg::SHIFT_W'(1);
      end
      if (capture) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      median_half_units <= (count == '0) ? '0 : med;
      all_missing       <= (count == '0);
      overflow          <= overflow_seen;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= lmm_pkg::CNT_W'(lmm_pkg::MAX_LINE))
    else $error("stored sample count beyond chain length");

  a_line_end_drains: assert property (@(posedge clk) disable iff (rst)
    accept && last_in_line |=> state == lmm_pkg::S_DRAIN)
    else $error("line end did not start the drain");

  a_capture_clears: assert property (@(posedge clk) disable iff (rst)
    capture |=> count == '0 && !overflow_seen && out_valid)
    else $error("line state not cleared after result capture");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    capture && count == '0 |=> all_missing && median_half_units == '0)
    else $error("empty line gave a nonzero median");

endmodule
